// ===== design/assert_macros.svh =====
// Assertion helpers shared by the mailbox responder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define MBR_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define MBR_IMPLIES_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mbr_pkg.sv =====
package mbr_pkg;

  localparam int WindowBytesDefault = 4096;

  // Word indexes of the special registers
  localparam logic [9:0] IdxCtrl  = 10'h004;
  localparam logic [9:0] IdxStat  = 10'h007;
  localparam logic [9:0] IdxStat2 = 10'h008;
  localparam logic [9:0] IdxResp  = 10'h040;
  localparam logic [9:0] IdxReq   = 10'h080;

  // Endpoint codes, the bootstrap op codes and the response op constants
  localparam logic [7:0] EpNone     = 8'h00;
  localparam logic [7:0] EpBoot     = 8'hff;
  localparam logic [7:0] OpBootOne  = 8'd2;
  localparam logic [7:0] OpBootA0   = 8'd3;
  localparam logic [7:0] OpBootA5   = 8'd4;
  localparam logic [7:0] OpBootTag  = 8'd16;
  localparam logic [7:0] OpBoot5A   = 8'd31;
  localparam logic [8:0] RopOffset  = 9'd100;
  localparam logic [8:0] RopNone    = 9'd1;

  typedef enum logic [1:0] {
    STEP_RESP = 2'd0,
    STEP_PAD  = 2'd1,
    STEP_STAT = 2'd2
  } resp_step_t;

  typedef struct packed {
    logic       clr;
    logic       acc;
    logic       resp;
    resp_step_t resp_step;
    logic       load_rd;
  } mbr_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_write;
    logic is_req;
  } mbr_sts_t;

  function automatic logic [31:0] boot_data(input logic [7:0] op, input logic [7:0] tag);
    logic [7:0] tag_nz;
    logic [31:0] d;
    tag_nz = (tag != 8'h00) ? tag : 8'h01;
    case (op)
      OpBootOne: d = 32'h0000_0001;
      OpBootA0:  d = 32'h0000_00a0;
      OpBootA5:  d = 32'hA5A5_0000 | {24'h0, tag};
      OpBootTag: d = 32'h0001_0000 | {24'h0, tag_nz};
      OpBoot5A:  d = 32'h5A5A_0000 | {16'h0, tag, 8'h01};
      default:   d = 32'h0;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] resp_word(input logic [7:0] ep, input logic [7:0] tag,
                                            input logic [7:0] op);
    logic [8:0] rop;
    rop = (ep == EpNone) ? RopNone : ({1'b0, op} + RopOffset);
    return {7'h0, rop, tag, ep};
  endfunction

endpackage

// ===== design/coprocessor_mailbox_responder.sv =====
// Channel | Handshake            | Payload
// --------+----------------------+---------------------------------------
// in      | in_valid / in_ready  | action, word_index, wide, write_data
// out     | out_valid / out_ready| read_data, irq_level
//
// On a read the transfer addresses both RAM banks; the registered read data
// lands in the output register in the cycle after.
// A plain write completes at acceptance; after a write to the request word
// the response and status words go out two per cycle over the two bank ports.
// After reset the block sweeps zeros through the register store, one even/odd
// word pair a cycle, with in_ready low throughout.
// A stalled result is held in the output register; once the block is idle,
// the next transfer is taken in the cycle that result leaves.
module coprocessor_mailbox_responder import mbr_pkg::*; #(
  parameter int WINDOW_BYTES = WindowBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [9:0]  word_index,
  input  logic        wide,
  input  logic [63:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] read_data,
  output logic        irq_level
);

  mbr_cmd_t cmd;
  mbr_sts_t sts;

  // Sequencing: clearing pass, bus transfers, response write-back
  mbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready),
    .out_valid(out_valid)
  );

  // Register store in two banks, interrupt flag and result register
  mbr_dp #(.WINDOW_BYTES(WINDOW_BYTES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .action    (action),
    .word_index(word_index),
    .wide      (wide),
    .write_data(write_data),
    .read_data (read_data),
    .irq_level (irq_level)
  );

endmodule

// ===== design/mbr_ram.sv =====
module mbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/mbr_ctrl.sv =====
`include "assert_macros.svh"

module mbr_ctrl import mbr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_ready,
  input  mbr_sts_t sts,
  output mbr_cmd_t cmd,
  output logic     in_ready,
  output logic     out_valid
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_RESP0 = 6'b001000,
    S_RESP1 = 6'b010000,
    S_RESP2 = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   load_out;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    cmd           = '0;
    cmd.resp_step = STEP_RESP;
    cmd.clr       = (state == S_CLEAR);
    cmd.acc       = in_valid && in_ready;
    cmd.load_rd   = (state == S_READ);
    state_next    = state;
    unique case (state)
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.acc) begin
          if (!sts.is_write) state_next = S_READ;
          else if (sts.is_req) state_next = S_RESP0;
        end
      end
      S_READ: state_next = S_IDLE;
      S_RESP0: begin
        cmd.resp      = 1'b1;
        cmd.resp_step = STEP_RESP;
        state_next    = S_RESP1;
      end
      S_RESP1: begin
        cmd.resp      = 1'b1;
        cmd.resp_step = STEP_PAD;
        state_next    = S_RESP2;
      end
      S_RESP2: begin
        cmd.resp      = 1'b1;
        cmd.resp_step = STEP_STAT;
        state_next    = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Writes finish at acceptance; reads in the cycle after
  assign load_out = cmd.load_rd || (cmd.acc && sts.is_write);

  always_comb begin
    out_valid_next = out_valid;
    if (load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `MBR_IMPLIES(a_no_overwrite, clk, rst, load_out, !out_valid || out_ready, "result overwritten")
  `MBR_IMPLIES_NEXT(a_resp_seq, clk, rst, cmd.acc && sts.is_req, (state == S_RESP0) ##1 (state == S_RESP1) ##1 (state == S_RESP2), "response sequence broken")

endmodule

// ===== design/mbr_dp.sv =====
`include "assert_macros.svh"

module mbr_dp import mbr_pkg::*; #(
  parameter int WINDOW_BYTES = WindowBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  mbr_cmd_t    cmd,
  output mbr_sts_t    sts,
  input  logic        action,
  input  logic [9:0]  word_index,
  input  logic        wide,
  input  logic [63:0] write_data,
  output logic [63:0] read_data,
  output logic        irq_level
);

  localparam int WinWords  = WINDOW_BYTES / 4;
  localparam int EvenDepth = (WinWords + 1) / 2;
  localparam int OddDepth  = WinWords / 2;
  localparam int EAW       = $clog2(EvenDepth);
  localparam int OAW       = $clog2(OddDepth);

  localparam logic [10:0]  WinLimit = 11'(WinWords);
  localparam logic [EAW:0] OddLimit = (EAW + 1)'(OddDepth);
  localparam logic [9:0]   RespLo   = IdxResp >> 1;
  localparam logic [9:0]   PadLo    = (IdxResp + 10'd2) >> 1;
  localparam logic [9:0]   Stat2Lo  = IdxStat2 >> 1;
  localparam logic [9:0]   StatLo   = IdxStat >> 1;
  localparam logic         ReqFits  = ({1'b0, IdxReq} + 11'd1) < WinLimit;

  // Even words live in one bank, odd words in the other
  logic           e_we, o_we;
  logic [EAW-1:0] e_addr;
  logic [OAW-1:0] o_addr;
  logic [31:0]    e_wd, o_wd, e_rd, o_rd;

  logic [10:0]    hi_idx;
  logic [9:0]     e_full;
  logic [8:0]     o_full;
  logic           lo_ok, hi_ok;

  logic [EAW-1:0] clr_cnt;
  logic           clr_odd_ok;

  logic [31:0]    resp_word_q, resp_data_q;
  logic           rd_swap, rd_lo_ok, rd_hi_ok;
  logic           irq_pending, irq_next;
  logic [31:0]    rd_lo, rd_hi;

  assign hi_idx = {1'b0, word_index} + 11'd1;
  assign e_full = hi_idx[10:1];
  assign o_full = word_index[9:1];
  assign lo_ok  = {1'b0, word_index} < WinLimit;
  assign hi_ok  = wide && (hi_idx < WinLimit);

  assign clr_odd_ok   = {1'b0, clr_cnt} < OddLimit;
  assign sts.clr_last = clr_cnt == EAW'(EvenDepth - 1);
  assign sts.is_write = action;
  assign sts.is_req   = action && (word_index == IdxReq) && ReqFits;

  always_comb begin
    e_we   = 1'b0;
    o_we   = 1'b0;
    e_addr = e_full[EAW-1:0];
    o_addr = o_full[OAW-1:0];
    e_wd   = word_index[0] ? write_data[63:32] : write_data[31:0];
    o_wd   = word_index[0] ? write_data[31:0] : write_data[63:32];
    if (cmd.clr) begin
      e_addr = clr_cnt;
      o_addr = clr_cnt[OAW-1:0];
      e_wd   = '0;
      o_wd   = '0;
      e_we   = 1'b1;
      o_we   = clr_odd_ok;
    end else if (cmd.resp) begin
      e_wd = '0;
      o_wd = '0;
      e_we = 1'b1;
      o_we = 1'b1;
      unique case (cmd.resp_step)
        STEP_RESP: begin
          e_addr = RespLo[EAW-1:0];
          o_addr = RespLo[OAW-1:0];
          e_wd   = resp_word_q;
          o_wd   = resp_data_q;
        end
        STEP_PAD: begin
          e_addr = PadLo[EAW-1:0];
          o_addr = PadLo[OAW-1:0];
        end
        STEP_STAT: begin
          e_addr = Stat2Lo[EAW-1:0];
          o_addr = StatLo[OAW-1:0];
        end
        default: begin
          e_we = 1'b0;
          o_we = 1'b0;
        end
      endcase
    end else if (cmd.acc && action) begin
      e_we = word_index[0] ? hi_ok : lo_ok;
      o_we = word_index[0] ? lo_ok : hi_ok;
    end
  end

  mbr_ram #(.WIDTH(32), .DEPTH(EvenDepth)) u_even (
    .clk  (clk),
    .we   (e_we),
    .addr (e_addr),
    .wdata(e_wd),
    .rdata(e_rd)
  );

  mbr_ram #(.WIDTH(32), .DEPTH(OddDepth)) u_odd (
    .clk  (clk),
    .we   (o_we),
    .addr (o_addr),
    .wdata(o_wd),
    .rdata(o_rd)
  );

  always_comb begin
    irq_next = irq_pending;
    if (!action) begin
      if (word_index == IdxResp || word_index == IdxStat) irq_next = 1'b0;
    end else begin
      if (word_index == IdxStat || word_index == IdxCtrl) irq_next = 1'b0;
      if (sts.is_req) irq_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      irq_pending <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + EAW'(1);
      if (cmd.acc) irq_pending <= irq_next;
    end
  end

  assign rd_lo = rd_swap ? o_rd : e_rd;
  assign rd_hi = rd_swap ? e_rd : o_rd;

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      rd_swap  <= word_index[0];
      rd_lo_ok <= lo_ok;
      rd_hi_ok <= hi_ok && lo_ok;
    end
    if (cmd.acc && sts.is_req) begin
      resp_word_q <= resp_word(write_data[7:0], write_data[15:8], write_data[23:16]);
      resp_data_q <= (write_data[7:0] == EpBoot)
                     ? boot_data(write_data[23:16], write_data[15:8]) : 32'h0;
    end
    if (cmd.acc && action) begin
      read_data <= '0;
      irq_level <= irq_next;
    end else if (cmd.load_rd) begin
      read_data <= {rd_hi_ok ? rd_hi : 32'h0, rd_lo_ok ? rd_lo : 32'h0};
      irq_level <= irq_pending;
    end
  end

  `MBR_IMPLIES_NEXT(a_irq_on_req, clk, rst, cmd.acc && sts.is_req, irq_pending, "request left interrupt low")
  `MBR_IMPLIES(a_outside_quiet, clk, rst, cmd.acc && action && !lo_ok, !(e_we || o_we), "write outside window stored")

endmodule

// ===== bench/tb.sv =====
module tb import mbr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Window under test and the number of word registers it exposes
  localparam int WIN_BYTES = WindowBytesDefault;
  localparam int WIN_WORDS = (WIN_BYTES / 4 > 1024) ? 1024 : WIN_BYTES / 4;

  // Bus access kinds
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam int RANDOM_ACCESSES = 1050;

  typedef struct {
    logic        act;
    logic [9:0]  idx;
    logic        wide;
    logic [63:0] data;
  } access_t;

  typedef struct {
    logic [63:0] read_data;
    logic        irq_level;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = ACT_READ;
  logic [9:0]  word_index = '0;
  logic        wide = 1'b0;
  logic [63:0] write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] read_data;
  logic        irq_level;

  coprocessor_mailbox_responder #(
    .WINDOW_BYTES(WIN_BYTES)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .word_index(word_index),
    .wide      (wide),
    .write_data(write_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .irq_level (irq_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus waiting to go out, and the replies the shadow mailbox says are due
  access_t accesses_pending[$];
  reply_t  replies_due[$];

  // Shadow copy of the register store and the interrupt line
  logic [31:0] shadow_words[1024];
  logic        shadow_irq;

  int accesses_total = 0;
  int accesses_done  = 0;
  int mismatches     = 0;
  int reads_seen     = 0;
  int writes_seen    = 0;
  int requests_seen  = 0;
  int boot_requests  = 0;
  int irq_high_seen  = 0;

  // --------------------------------------------------------------------------
  // Shadow mailbox: apply one access to the shadow state and return the reply
  // the block should give for it.
  // --------------------------------------------------------------------------
  function automatic reply_t mailbox_predict(access_t a);
    reply_t      r;
    int          i;
    logic [31:0] lo;
    logic [7:0]  ep;
    logic [7:0]  tag;
    logic [7:0]  op;
    logic [8:0]  rop;
    logic [31:0] boot;
    r.read_data = '0;
    i = int'(a.idx);
    if (a.act == ACT_READ) begin
      reads_seen++;
      if (i < WIN_WORDS) begin
        r.read_data[31:0] = shadow_words[i];
        // the upper half of a wide read past the window end reads as zero
        if (a.wide && i + 1 < WIN_WORDS) begin
          r.read_data[63:32] = shadow_words[i + 1];
        end
      end
      if (a.idx == IdxResp || a.idx == IdxStat) begin
        shadow_irq = 1'b0;
      end
    end else begin
      writes_seen++;
      if (i < WIN_WORDS) begin
        shadow_words[i] = a.data[31:0];
        if (a.wide && i + 1 < WIN_WORDS) begin
          shadow_words[i + 1] = a.data[63:32];
        end
      end
      // only the exact word index clears; a wide write that merely covers
      // the status word leaves the interrupt alone
      if (a.idx == IdxStat || a.idx == IdxCtrl) begin
        shadow_irq = 1'b0;
      end
      if (a.idx == IdxReq && i + 1 < WIN_WORDS) begin
        lo  = shadow_words[IdxReq];
        ep  = lo[7:0];
        tag = lo[15:8];
        op  = lo[23:16];
        rop = {1'b0, op} + 9'd100;
        boot = '0;
        requests_seen++;
        if (ep == EpNone) begin
          rop = RopNone;
        end else if (ep == EpBoot) begin
          boot_requests++;
          case (op)
            OpBootOne: boot = 32'h0000_0001;
            OpBootA0:  boot = 32'h0000_00a0;
            OpBootA5:  boot = {24'hA5A500, tag};
            OpBootTag: boot = {24'h000100, (tag == 8'h00) ? 8'h01 : tag};
            OpBoot5A:  boot = {16'h5A5A, tag, 8'h01};
            default:   boot = '0;
          endcase
        end
        shadow_words[IdxResp]     = {7'h00, rop, tag, ep};
        shadow_words[IdxResp + 1] = boot;
        shadow_words[IdxResp + 2] = '0;
        shadow_words[IdxResp + 3] = '0;
        shadow_words[IdxStat]     = '0;
        shadow_words[IdxStat2]    = '0;
        shadow_irq = 1'b1;
      end
    end
    r.irq_level = shadow_irq;
    if (shadow_irq) begin
      irq_high_seen++;
    end
    return r;
  endfunction

  function automatic void push_access(logic act, logic [9:0] idx, logic w, logic [63:0] d);
    access_t a;
    a.act  = act;
    a.idx  = idx;
    a.wide = w;
    a.data = d;
    accesses_pending.push_back(a);
    accesses_total++;
  endfunction

  // Request word with random filler in bits 24-31 and in the high word
  function automatic logic [63:0] request_word(logic [7:0] ep, logic [7:0] tag,
                                               logic [7:0] op);
    logic [31:0] hi;
    logic [7:0]  top;
    hi  = $urandom;
    top = 8'($urandom_range(0, 255));
    return {hi, top, op, tag, ep};
  endfunction

  function automatic logic [63:0] random_word64();
    return {$urandom, $urandom};
  endfunction

  // Wait draw for one side: mostly a uniformly drawn random wait, with occasional stretches
  // of back-to-back transfers.
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Push one well-formed request with random endpoint, tag and op; the boot
  // endpoint gets half of them so that its op decode is well exercised.
  function automatic void push_random_request();
    logic [7:0] ep;
    logic [7:0] tag;
    logic [7:0] op;
    case ($urandom_range(0, 7))
      0, 1:    ep = EpNone;
      2, 3:    ep = 8'($urandom_range(1, 254));
      default: ep = EpBoot;
    endcase
    tag = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       op = OpBootOne;
      1:       op = OpBootA0;
      2:       op = OpBootA5;
      3:       op = OpBootTag;
      4:       op = OpBoot5A;
      default: op = 8'($urandom_range(0, 255));
    endcase
    push_access(ACT_WRITE, IdxReq, 1'($urandom_range(0, 1)), request_word(ep, tag, op));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present the next pending access, hold it until the transfer,
  // then wait the drawn number of cycles before the next one.
  // --------------------------------------------------------------------------
  access_t in_cur;
  int      in_wait  = 0;
  int      in_burst = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_wait = draw_wait(in_burst);
    end else begin
      if (in_valid && in_ready) begin
        replies_due.push_back(mailbox_predict(in_cur));
        accesses_done++;
        in_wait = draw_wait(in_burst);
      end
      // the slot is free once nothing is held or the held access just went
      if (!in_valid || in_ready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (accesses_pending.size() > 0) begin
          in_cur = accesses_pending.pop_front();
          action     <= in_cur.act;
          word_index <= in_cur.idx;
          wide       <= in_cur.wide;
          write_data <= in_cur.data;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each reply transfer against the oldest reply due, then
  // hold out_ready low for the drawn number of cycles.
  // --------------------------------------------------------------------------
  reply_t out_due;
  int     out_hold  = 0;
  int     out_burst = 0;

  task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected reply", '0, read_data);
        end else begin
          out_due = replies_due.pop_front();
          if (read_data !== out_due.read_data) begin
            report_mismatch("read_data", out_due.read_data, read_data);
          end
          if (irq_level !== out_due.irq_level) begin
            report_mismatch("irq_level", 64'(out_due.irq_level), 64'(irq_level));
          end
        end
        out_hold = draw_wait(out_burst);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int         kind;
    int         cnt;
    int         k;
    logic [9:0] edge_idx[8];

    foreach (shadow_words[j]) shadow_words[j] = '0;
    shadow_irq = 1'b0;

    edge_idx = '{IdxReq + 10'd1, IdxReq - 10'd1, IdxStat - 10'd1, IdxStat2,
                 IdxCtrl, 10'h3FF, 10'h3FE, IdxResp + 10'd3};

    // Directed part: reset contents, window end, the non-request word at
    // 0x204, every boot op, the spill of the response op past eight bits and
    // each way of dropping the interrupt.
    push_access(ACT_READ,  IdxResp, 1'b0, '0);
    push_access(ACT_READ,  10'h3FF, 1'b1, '0);
    push_access(ACT_WRITE, 10'h3FF, 1'b1, '1);
    push_access(ACT_READ,  10'h3FE, 1'b1, '0);
    push_access(ACT_WRITE, IdxReq + 10'd1, 1'b0, 64'h0000_0000_DEAD_BEEF);
    push_access(ACT_WRITE, IdxReq, 1'b0, request_word(EpNone, 8'h5A, 8'h33));
    push_access(ACT_READ,  IdxResp, 1'b1, '0);
    push_access(ACT_READ,  IdxStat, 1'b0, '0);
    push_access(ACT_WRITE, IdxReq, 1'b1, request_word(EpBoot, 8'h00, OpBootTag));
    push_access(ACT_WRITE, IdxStat - 10'd1, 1'b1, 64'h1234_5678_9ABC_DEF0);
    push_access(ACT_WRITE, IdxCtrl, 1'b0, '0);
    push_access(ACT_WRITE, IdxReq, 1'b0, request_word(EpBoot, 8'h3C, OpBootOne));
    push_access(ACT_READ,  IdxResp, 1'b0, '0);
    push_access(ACT_WRITE, IdxReq, 1'b0, request_word(EpBoot, 8'hFF, OpBootA0));
    push_access(ACT_WRITE, IdxStat, 1'b0, '1);
    push_access(ACT_WRITE, IdxReq, 1'b1, request_word(EpBoot, 8'hA5, OpBootA5));
    push_access(ACT_READ,  IdxResp, 1'b1, '0);
    push_access(ACT_WRITE, IdxReq, 1'b0, request_word(EpBoot, 8'hFF, OpBoot5A));
    push_access(ACT_READ,  IdxResp + 10'd1, 1'b1, '0);
    push_access(ACT_WRITE, IdxReq, 1'b0, request_word(8'h12, 8'h34, 8'hFF));
    push_access(ACT_READ,  IdxResp, 1'b0, '0);
    push_access(ACT_WRITE, IdxReq, 1'b0, request_word(EpBoot, 8'h01, 8'h07));
    push_access(ACT_READ,  IdxStat, 1'b1, '0);
    push_access(ACT_READ,  IdxStat2, 1'b0, '0);
    push_access(ACT_WRITE, IdxReq, 1'b1, '1);

    // Random part: mostly request / read-back / acknowledge sequences, the rest
    // noise across the whole window, accesses around the edges and runs of requests.
    cnt = accesses_total;
    while (accesses_total - cnt < RANDOM_ACCESSES) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4, 5: begin
          push_random_request();
          k = $urandom_range(0, 3);
          repeat (k) begin
            push_access(ACT_READ, IdxResp + 10'($urandom_range(0, 3)),
                        1'($urandom_range(0, 1)), random_word64());
          end
          // acknowledge in one of the ways the block honours, or not at all
          case ($urandom_range(0, 4))
            0: push_access(ACT_READ,  IdxResp, 1'($urandom_range(0, 1)), random_word64());
            1: push_access(ACT_READ,  IdxStat, 1'($urandom_range(0, 1)), random_word64());
            2: push_access(ACT_WRITE, IdxStat, 1'($urandom_range(0, 1)), random_word64());
            3: push_access(ACT_WRITE, IdxCtrl, 1'($urandom_range(0, 1)), random_word64());
            default: ;
          endcase
        end
        6, 7: begin
          k = $urandom_range(1, 4);
          repeat (k) begin
            push_access(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                        1'($urandom_range(0, 1)), random_word64());
          end
        end
        8: begin
          push_access(1'($urandom_range(0, 1)), edge_idx[$urandom_range(0, 7)],
                      1'($urandom_range(0, 1)), random_word64());
        end
        default: begin
          k = $urandom_range(2, 3);
          repeat (k) push_random_request();
        end
      endcase
    end

    // Hold until the last access has been transferred and every reply is in
    while (accesses_done < accesses_total || replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d reads and %0d writes, %0d requests answered (%0d to the boot",
             reads_seen, writes_seen, requests_seen, boot_requests);
    $display("endpoint), %0d replies with the interrupt raised; %0d mismatches",
             irq_high_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Release reset after the hold-off; it is never asserted again
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Drop the run if it hangs: well beyond the slowest legal schedule
  initial begin
    #3_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
